[hw/rtl/tsw_pkg.sv]
package tsw_pkg;

  localparam int unsigned QueueDepthDefault   = 64;
  localparam int unsigned MaxSegsDefault      = 64;
  localparam logic [10:0] SegLimit            = 11'd1452;
  localparam logic [15:0] InitialRtoReset     = 16'd1000;
  localparam logic [10:0] MaxPayloadReset     = 11'd1000;

  // Input actions.
  localparam logic [1:0] ActFill  = 2'd0;
  localparam logic [1:0] ActAck   = 2'd1;
  localparam logic [1:0] ActTick  = 2'd2;
  localparam logic [1:0] ActEmpty = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CfgInitialRto = 2'd0;
  localparam logic [1:0] CfgIsn        = 2'd1;
  localparam logic [1:0] CfgMaxPayload = 2'd2;

  // Queue entry: seq, len, syn, fin (45 bits).
  typedef struct packed {
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
  } entry_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // latch input item
    logic fill_syn;  // emit SYN and push
    logic fill_seg;  // emit one data segment and push
    logic ack_upd;   // record window and unwrap ack
    logic pop;       // pop head entry
    logic ack_done;  // finish ack bookkeeping
    logic tick_upd;  // advance timer
    logic tick_retx; // retransmit head
    logic tick_stop; // stop idle timer
    logic emit_none; // emit empty status result
    logic emit_empty;// emit empty segment
    logic rd_head;   // read head entry from queue
    logic last;      // this result is the final one
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] action;
    logic       syn_done;
    logic       q_full;
    logic       q_empty;
    logic       seg_ok;     // next fill segment may be emitted
    logic       seg_final;  // no segment can follow this one
    logic       ack_take;   // ack is new and in range
    logic       pop_ok;     // head entry is fully acknowledged
    logic       timeout;    // retransmission due
    logic       out_busy;   // output register holds a beat not yet taken
  } stat_t;

endpackage

[hw/rtl/tsw_ram.sv]
module tsw_ram #(
  parameter int unsigned Width = 45,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/tsw_datapath.sv]
module tsw_datapath import tsw_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [82:0] in_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [70:0] out_data_o,
  output logic        out_last_o,
  input  logic        seg_cnt_max_i
);

  localparam int unsigned Aw = $clog2(QueueDepth);
  localparam int unsigned Cw = $clog2(QueueDepth + 1);

  // Configuration registers.
  logic [15:0] initial_rto_q;
  logic [31:0] isn_q;
  logic [10:0] max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_rto_q <= InitialRtoReset;
      isn_q         <= '0;
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInitialRto: initial_rto_q <= cfg_data_i[15:0];
        CfgIsn:        isn_q         <= cfg_data_i;
        CfgMaxPayload: max_payload_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [1:0]  action_q;
  logic [31:0] ackno_q;
  logic [15:0] window_q, ms_q, ready_q;
  logic        ended_q;

  // Protocol state.
  logic        syn_done_q, fin_done_q, zero_window_q, timer_on_q;
  logic [63:0] next_abs_q, acked_abs_q, ack_abs_q;
  logic [15:0] send_window_q;
  logic [31:0] elapsed_q, cur_rto_q;
  logic [7:0]  retry_q;
  logic [Aw-1:0] head_q;
  logic [Cw-1:0] count_q;
  logic        ack_take_q;

  // Unwrap a sequence number against a checkpoint.
  function automatic logic [63:0] unwrap(input logic [31:0] n, input logic [31:0] base,
                                         input logic [63:0] cp);
    logic [63:0] cand;
    cand = {cp[63:32], n - base};
    if (cand > cp) begin
      if ((cand - cp) > 64'h8000_0000 && cand[63:32] != 32'd0) cand = cand - 64'h1_0000_0000;
    end else begin
      if ((cp - cand) > 64'h8000_0000 && cand[63:32] != 32'hFFFF_FFFF)
        cand = cand + 64'h1_0000_0000;
    end
    return cand;
  endfunction

  // Fill segment arithmetic.
  logic [63:0] inflight;
  logic [15:0] room;
  logic [10:0] mp, seg_n;
  logic [15:0] ready_left;
  logic        seg_fin;

  always_comb begin
    inflight = next_abs_q - acked_abs_q;
    room = (inflight < {48'd0, send_window_q}) ? send_window_q - inflight[15:0] : 16'd0;
    mp = (max_payload_q == 11'd0) ? 11'd1 : ((max_payload_q > SegLimit) ? SegLimit
                                                                        : max_payload_q);
    seg_n = mp;
    if ({5'd0, seg_n} > room) seg_n = room[10:0];
    if ({5'd0, seg_n} > ready_q) seg_n = ready_q[10:0];
    ready_left = ready_q - {5'd0, seg_n};
    seg_fin = ended_q && ready_left == 16'd0 && {5'd0, seg_n} < room;
  end

  // Queue.
  entry_t wr_entry, head_entry;
  logic   q_we;
  logic [Aw:0] wpos_full;
  logic [Aw-1:0] wpos;

  always_comb begin
    wpos_full = {1'b0, head_q} + count_q[Aw:0];
    wpos = (wpos_full >= (Aw+1)'(QueueDepth)) ? Aw'(wpos_full - (Aw+1)'(QueueDepth))
                                               : wpos_full[Aw-1:0];
    q_we = cmd_i.fill_syn || cmd_i.fill_seg;
    wr_entry.seq = next_abs_q[31:0] + isn_q;
    wr_entry.len = cmd_i.fill_syn ? 11'd0 : seg_n;
    wr_entry.syn = cmd_i.fill_syn;
    wr_entry.fin = cmd_i.fill_syn ? 1'b0 : seg_fin;
  end

  logic [44:0] rdata;
  tsw_ram #(.Width(45), .Depth(QueueDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (wpos),
    .wdata_i (wr_entry),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );
  assign head_entry = entry_t'(rdata);

  // Pop test for the head entry.
  logic [63:0] head_start, head_end;
  always_comb begin
    head_start = unwrap(head_entry.seq, isn_q, acked_abs_q);
    head_end = head_start + {53'd0, head_entry.len} + {63'd0, head_entry.syn}
             + {63'd0, head_entry.fin};
  end

  // Timer arithmetic.
  logic [32:0] el_sum;
  logic [31:0] el_new;
  always_comb begin
    el_sum = {1'b0, elapsed_q} + {17'd0, ms_q};
    el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  end

  // Output beat register.
  logic        ov_q, o_last_q;
  logic [70:0] o_data_q;
  logic        emit;
  logic        e_valid, e_syn, e_fin, e_retx;
  logic [31:0] e_seq;
  logic [10:0] e_len;
  logic [63:0] next_abs_d;
  logic [15:0] flight_d;
  logic [7:0]  retry_d;

  always_comb begin
    emit = cmd_i.fill_syn || cmd_i.fill_seg || cmd_i.emit_none || cmd_i.emit_empty
        || cmd_i.tick_retx;
    e_valid = !cmd_i.emit_none;
    e_seq = '0; e_len = '0; e_syn = 1'b0; e_fin = 1'b0; e_retx = 1'b0;
    next_abs_d = next_abs_q;
    retry_d = retry_q;
    if (cmd_i.fill_syn) begin
      e_seq = wr_entry.seq; e_syn = 1'b1; next_abs_d = next_abs_q + 64'd1;
    end else if (cmd_i.fill_seg) begin
      e_seq = wr_entry.seq; e_len = seg_n; e_fin = seg_fin;
      next_abs_d = next_abs_q + {53'd0, seg_n} + {63'd0, seg_fin};
    end else if (cmd_i.emit_empty) begin
      e_seq = next_abs_q[31:0] + isn_q;
    end else if (cmd_i.tick_retx) begin
      e_seq = head_entry.seq; e_len = head_entry.len; e_syn = head_entry.syn;
      e_fin = head_entry.fin; e_retx = 1'b1;
      if (retry_q != 8'hFF) retry_d = retry_q + 8'd1;
    end
    // A new acknowledgment clears the retry count before its status beat.
    if (cmd_i.ack_done) retry_d = '0;
    flight_d = ((next_abs_d - acked_abs_q) > 64'hFFFF) ? 16'hFFFF
             : 16'(next_abs_d - acked_abs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_data_q <= {retry_d, flight_d, e_retx, e_fin, e_syn, e_len, e_seq, e_valid};
      o_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = o_data_q;
  assign out_last_o  = o_last_q;

  // Payload latch; the ready count shrinks as segments are cut.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_data_i[1:0];
      ackno_q  <= in_data_i[33:2];
      window_q <= in_data_i[49:34];
      ms_q     <= in_data_i[65:50];
      ready_q  <= in_data_i[81:66];
      ended_q  <= in_data_i[82];
    end else if (cmd_i.fill_seg) begin
      ready_q <= ready_left;
    end
  end

  // State updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_done_q <= 1'b0; fin_done_q <= 1'b0; zero_window_q <= 1'b0; timer_on_q <= 1'b0;
      next_abs_q <= '0; acked_abs_q <= '0; ack_abs_q <= '0;
      send_window_q <= 16'd1; elapsed_q <= '0; cur_rto_q <= {16'd0, InitialRtoReset};
      retry_q <= '0; head_q <= '0; count_q <= '0; ack_take_q <= 1'b0;
    end else begin
      next_abs_q <= next_abs_d;
      retry_q <= retry_d;
      if (cmd_i.fill_syn) syn_done_q <= 1'b1;
      if (cmd_i.fill_seg && seg_fin) fin_done_q <= 1'b1;
      if (q_we) begin
        count_q <= count_q + Cw'(1);
        if (!timer_on_q) begin
          timer_on_q <= 1'b1; elapsed_q <= '0;
        end
      end
      if (cmd_i.ack_upd) begin
        send_window_q <= (window_q == 16'd0) ? 16'd1 : window_q;
        zero_window_q <= (window_q == 16'd0);
        ack_abs_q <= unwrap(ackno_q, isn_q, acked_abs_q);
        ack_take_q <= 1'b0;
      end
      // The range test is made on the first head read of an ack only.
      if (cmd_i.rd_head && action_q == ActAck && !ack_take_q) begin
        ack_take_q <= !(ack_abs_q > next_abs_q || ack_abs_q <= acked_abs_q);
        if (!(ack_abs_q > next_abs_q || ack_abs_q <= acked_abs_q)) acked_abs_q <= ack_abs_q;
      end
      if (cmd_i.pop) begin
        head_q <= (head_q == Aw'(QueueDepth - 1)) ? '0 : head_q + Aw'(1);
        count_q <= count_q - Cw'(1);
      end
      if (cmd_i.ack_done) begin
        timer_on_q <= count_q != '0;
        elapsed_q <= '0;
        cur_rto_q <= {16'd0, initial_rto_q};
      end
      if (cmd_i.tick_upd && timer_on_q) elapsed_q <= el_new;
      if (cmd_i.tick_retx) begin
        elapsed_q <= '0;
        if (!zero_window_q) cur_rto_q <= cur_rto_q[31] ? 32'hFFFF_FFFF : {cur_rto_q[30:0], 1'b0};
      end
      if (cmd_i.tick_stop && count_q == '0) timer_on_q <= 1'b0;
    end
  end

  // Status.
  always_comb begin
    stat_o.action    = action_q;
    stat_o.syn_done  = syn_done_q;
    stat_o.q_full    = count_q >= Cw'(QueueDepth);
    stat_o.q_empty   = count_q == '0;
    stat_o.seg_ok    = !fin_done_q && room != 16'd0 && (seg_n != 11'd0 || seg_fin)
                    && count_q < Cw'(QueueDepth);
    stat_o.seg_final = seg_fin || seg_cnt_max_i || count_q + Cw'(1) >= Cw'(QueueDepth)
                    || (room - {5'd0, seg_n}) == 16'd0
                    || (ready_left == 16'd0 && !ended_q);
    stat_o.ack_take  = ack_take_q;
    stat_o.pop_ok    = count_q != '0 && head_end <= acked_abs_q;
    stat_o.timeout   = timer_on_q && count_q != '0 && elapsed_q >= cur_rto_q;
    stat_o.out_busy  = ov_q && !out_ready_i;
  end

endmodule

[hw/rtl/tsw_ctrl.sv]
module tsw_ctrl import tsw_pkg::*; #(
  parameter int unsigned MaxSegs = MaxSegsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  seg_cnt_max_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDisp = 7'b0000010,
    StFill = 7'b0000100,
    StAckR = 7'b0001000,
    StAckP = 7'b0010000,
    StTick = 7'b0100000,
    StTkR  = 7'b1000000
  } state_e;

  localparam int unsigned Kw = $clog2(MaxSegs + 1);

  state_e state_q, state_d;
  logic [Kw-1:0] k_q, k_d;

  assign seg_cnt_max_o = (k_q + Kw'(1)) >= Kw'(MaxSegs);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = !stat_i.out_busy;
        if (in_valid_i && !stat_i.out_busy) begin
          cmd_o.load = 1'b1; state_d = StDisp; k_d = '0;
        end
      end
      StDisp: begin
        if (!stat_i.out_busy) begin
          unique case (stat_i.action)
            ActFill: begin
              if (!stat_i.syn_done) begin
                cmd_o.last = 1'b1;
                if (stat_i.q_full) cmd_o.emit_none = 1'b1;
                else cmd_o.fill_syn = 1'b1;
                state_d = StIdle;
              end else if (!stat_i.seg_ok) begin
                cmd_o.emit_none = 1'b1; cmd_o.last = 1'b1; state_d = StIdle;
              end else begin
                state_d = StFill;
              end
            end
            ActAck: begin
              cmd_o.ack_upd = 1'b1; state_d = StAckR;
            end
            ActTick: begin
              cmd_o.tick_upd = 1'b1; state_d = StTick;
            end
            default: begin
              cmd_o.emit_empty = 1'b1; cmd_o.last = 1'b1; state_d = StIdle;
            end
          endcase
        end
      end
      StFill: begin
        if (!stat_i.out_busy) begin
          cmd_o.fill_seg = 1'b1;
          k_d = k_q + Kw'(1);
          if (stat_i.seg_final) begin
            cmd_o.last = 1'b1; state_d = StIdle;
          end
        end
      end
      StAckR: begin
        cmd_o.rd_head = 1'b1; state_d = StAckP;
      end
      StAckP: begin
        if (!stat_i.ack_take) begin
          cmd_o.emit_none = 1'b1; cmd_o.last = 1'b1; state_d = StIdle;
        end else if (stat_i.pop_ok) begin
          cmd_o.pop = 1'b1; state_d = StAckR;
        end else begin
          cmd_o.ack_done = 1'b1; cmd_o.emit_none = 1'b1; cmd_o.last = 1'b1;
          state_d = StIdle;
        end
      end
      StTick: begin
        state_d = StTkR;
      end
      StTkR: begin
        cmd_o.last = 1'b1; state_d = StIdle;
        if (stat_i.timeout) cmd_o.tick_retx = 1'b1;
        else begin
          cmd_o.tick_stop = 1'b1; cmd_o.emit_none = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; k_q <= '0;
    end else begin
      state_q <= state_d; k_q <= k_d;
    end
  end

endmodule

[hw/rtl/tcp_sender_window_retransmit_core.sv]
// Sequence: an empty segment, a SYN or a fill that sends nothing gives its result beat
// from dispatch; a tick updates the timer first; an ack pops acked head entries
// first; a fill sends one segment per cycle (up to 64) while output is not stalled.
// Throughput: one item at a time; the sequencer walks the fill loop and the queue
// pops through the single read port of the pending-segment RAM.
// Reset: asynchronous, active low; clears all protocol state and restores
// configuration defaults. The pending queue holds no reset value.
module tcp_sender_window_retransmit_core import tsw_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  parameter int unsigned MaxSegs    = MaxSegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], ackno[33:2], window[49:34], elapsed_ms[65:50],
  // bytes_ready[81:66], input_ended[82], zero fill above
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seg_valid[0], seg_seqno[32:1], seg_length[43:33], seg_syn[44], seg_fin[45],
  // retransmit[46], in_flight[62:47], retries[70:63], zero fill above
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;
  logic  seg_cnt_max;
  logic [70:0] out_data;

  tsw_ctrl #(.MaxSegs(MaxSegs)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .seg_cnt_max_o (seg_cnt_max)
  );

  tsw_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_data_i     (s_axis_tdata[82:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (out_data),
    .out_last_o    (m_axis_tlast),
    .seg_cnt_max_i (seg_cnt_max)
  );

  assign m_axis_tdata = {1'b0, out_data};

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import tsw_pkg::*;

  localparam int unsigned QDepth     = 64;
  localparam int unsigned SegsPerFill = 64;
  localparam int unsigned StallLimit = 5000;

  // One outgoing segment descriptor as the block reports it.
  typedef struct {
    bit        vld;
    bit [31:0] seqno;
    bit [10:0] len;
    bit        syn;
    bit        fin;
    bit        retx;
    bit        last;
    bit [15:0] flight;
    bit [7:0]  retries;
  } seg_desc_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // action[1:0], ackno[33:2], window[49:34], elapsed_ms[65:50],
  // bytes_ready[81:66], input_ended[82], zero fill above
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // seg_valid[0], seg_seqno[32:1], seg_length[43:33], seg_syn[44], seg_fin[45],
  // retransmit[46], in_flight[62:47], retries[70:63], zero fill above
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  tcp_sender_window_retransmit_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copy of the sender state.
  bit [15:0] rto_init;
  bit [31:0] isn_cfg;
  bit [10:0] payload_cfg;
  bit        syn_sent, fin_sent, win_zero, timer_run;
  bit [63:0] next_seq_abs, acked_seq_abs;
  bit [31:0] peer_window, timer_ms, rto_now;
  bit [7:0]  retry_cnt;
  bit [31:0] q_seq [QDepth];
  bit [10:0] q_len [QDepth];
  bit        q_syn [QDepth];
  bit        q_fin [QDepth];
  int unsigned q_head, q_count;

  seg_desc_t expected_segs[$];
  bit        failed;
  bit        calm;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic bit [63:0] unwrap_seq(bit [31:0] n, bit [31:0] base, bit [63:0] cp);
    bit [63:0] cand;
    cand = {cp[63:32], n - base};
    if (cand > cp) begin
      if (cand - cp > 64'h8000_0000 && cand >= 64'h1_0000_0000) cand -= 64'h1_0000_0000;
    end else begin
      if (cp - cand > 64'h8000_0000 && cand <= 64'hFFFF_FFFE_FFFF_FFFF)
        cand += 64'h1_0000_0000;
    end
    return cand;
  endfunction

  function automatic bit [15:0] flight_now();
    bit [63:0] f;
    f = next_seq_abs - acked_seq_abs;
    return (f > 64'hFFFF) ? 16'hFFFF : f[15:0];
  endfunction

  function automatic void add_seg(bit vld, bit [31:0] seq, bit [10:0] len, bit syn, bit fin,
                                  bit retx, bit last);
    seg_desc_t d;
    d.vld = vld; d.seqno = seq; d.len = len; d.syn = syn; d.fin = fin;
    d.retx = retx; d.last = last; d.flight = flight_now(); d.retries = retry_cnt;
    expected_segs.push_back(d);
  endfunction

  function automatic void queue_seg(bit [31:0] seq, bit [10:0] len, bit syn, bit fin);
    int unsigned pos;
    pos = (q_head + q_count) % QDepth;
    q_seq[pos] = seq; q_len[pos] = len; q_syn[pos] = syn; q_fin[pos] = fin;
    q_count++;
    if (!timer_run) begin
      timer_run = 1'b1;
      timer_ms = 0;
    end
  endfunction

  // Fill: SYN first, then cut segments into the open window.
  function automatic void cut_segments(bit [31:0] ready, bit ended);
    int unsigned k;
    bit [31:0] mp, n, seq;
    bit [63:0] room, infl;
    bit fin;
    k = 0;
    if (!syn_sent) begin
      if (q_count >= QDepth) begin
        add_seg(0, 0, 0, 0, 0, 0, 1);
        return;
      end
      seq = next_seq_abs[31:0] + isn_cfg;
      queue_seg(seq, 0, 1, 0);
      next_seq_abs += 1;
      syn_sent = 1'b1;
      add_seg(1, seq, 0, 1, 0, 0, 1);
      return;
    end
    mp = (payload_cfg == 0) ? 1 : ((payload_cfg > SegLimit) ? SegLimit : payload_cfg);
    while (!fin_sent && k < SegsPerFill && q_count < QDepth) begin
      infl = next_seq_abs - acked_seq_abs;
      // A window smaller than what is in flight leaves no room at all.
      room = (peer_window > infl) ? peer_window - infl : 0;
      if (room == 0) break;
      n = mp;
      if (n > room) n = room[31:0];
      if (n > ready) n = ready;
      ready -= n;
      fin = ended && ready == 0 && n < room;
      if (n == 0 && !fin) break;
      seq = next_seq_abs[31:0] + isn_cfg;
      next_seq_abs += n + fin;
      if (fin) fin_sent = 1'b1;
      queue_seg(seq, n[10:0], 0, fin);
      add_seg(1, seq, n[10:0], 0, fin, 0, 0);
      k++;
    end
    if (k == 0) add_seg(0, 0, 0, 0, 0, 0, 1);
    else expected_segs[expected_segs.size() - 1].last = 1'b1;
  endfunction

  function automatic void take_ack(bit [31:0] ackno, bit [15:0] win);
    bit [63:0] ack, start, span;
    if (win == 0) begin
      peer_window = 1;
      win_zero = 1'b1;
    end else begin
      peer_window = win;
      win_zero = 1'b0;
    end
    ack = unwrap_seq(ackno, isn_cfg, acked_seq_abs);
    if (ack > next_seq_abs || ack <= acked_seq_abs) return;
    acked_seq_abs = ack;
    while (q_count > 0) begin
      start = unwrap_seq(q_seq[q_head], isn_cfg, acked_seq_abs);
      span = q_len[q_head] + q_syn[q_head] + q_fin[q_head];
      if (start + span > acked_seq_abs) break;
      q_head = (q_head + 1) % QDepth;
      q_count--;
    end
    timer_run = q_count > 0;
    timer_ms = 0;
    rto_now = rto_init;
    retry_cnt = 0;
  endfunction

  function automatic void run_timer(bit [31:0] ms);
    if (timer_run) timer_ms = (timer_ms > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF : timer_ms + ms;
    if (timer_run && q_count > 0 && timer_ms >= rto_now) begin
      if (retry_cnt < 8'd255) retry_cnt++;
      // A zero window probe does not back off.
      if (!win_zero) rto_now = (rto_now > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto_now * 2;
      timer_ms = 0;
      add_seg(1, q_seq[q_head], q_len[q_head], q_syn[q_head], q_fin[q_head], 1, 1);
      return;
    end
    if (q_count == 0) timer_run = 1'b0;
    add_seg(0, 0, 0, 0, 0, 0, 1);
  endfunction

  function automatic void predict_segs(bit [1:0] act, bit [31:0] ackno, bit [15:0] win,
                                       bit [15:0] ms, bit [15:0] ready, bit ended);
    case (act)
      ActFill: begin
        cut_segments(ready, ended);
      end
      ActAck: begin
        take_ack(ackno, win);
        add_seg(0, 0, 0, 0, 0, 0, 1);
      end
      ActTick: begin
        run_timer(ms);
      end
      default: begin
        add_seg(1, next_seq_abs[31:0] + isn_cfg, 0, 0, 0, 0, 1);
      end
    endcase
  endfunction

  // Present one item and hold it until the block takes the beat.
  task automatic send_item(bit [1:0] act, bit [31:0] ackno, bit [15:0] win, bit [15:0] ms,
                           bit [15:0] ready, bit ended);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_segs(act, ackno, win, ms, ready, ended);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, ended, ready, ms, win, ackno, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_ack(bit [31:0] ahead, bit [15:0] win);
    send_item(ActAck, isn_cfg + acked_seq_abs[31:0] + ahead, win, 0, 0, 0);
  endtask

  // Registers change only once every result of the previous items is back.
  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgInitialRto: rto_init = val[15:0];
      CfgIsn:        isn_cfg = val;
      default:       payload_cfg = val[10:0];
    endcase
  endtask

  function automatic bit [31:0] flight_abs();
    return next_seq_abs[31:0] - acked_seq_abs[31:0];
  endfunction

  // Handshake corners, window limits, stale acks and out-of-range payload sizes.
  task automatic test_directed();
    send_item(ActEmpty, 0, 0, 0, 0, 0);
    send_item(ActTick, 0, 0, 16'hFFFF, 0, 0);
    send_item(ActFill, 0, 0, 0, 16'hFFFF, 1);
    send_item(ActFill, 0, 0, 0, 100, 0);
    send_ack(1, 16'hFFFF);
    send_item(ActFill, 0, 0, 0, 0, 0);
    write_reg(CfgMaxPayload, 1);
    send_item(ActFill, 0, 0, 0, 200, 0);
    send_item(ActFill, 0, 0, 0, 200, 0);
    send_item(ActTick, 0, 0, 16'hFFFF, 0, 0);
    send_ack(5, 3);
    send_item(ActFill, 0, 0, 0, 50, 0);
    send_ack(0, 100);
    send_ack(flight_abs() + 100, 100);
    send_ack(2, 0);
    send_item(ActTick, 0, 0, 16'hFFFF, 0, 0);
    send_item(ActTick, 0, 0, 16'hFFFF, 0, 0);
    send_ack(flight_abs(), 3000);
    write_reg(CfgMaxPayload, 0);
    send_item(ActFill, 0, 0, 0, 7, 0);
    write_reg(CfgMaxPayload, 11'h7FF);
    send_item(ActFill, 0, 0, 0, 4000, 0);
    send_item(ActEmpty, 0, 0, 0, 0, 0);
    send_ack(flight_abs(), 16'hFFFF);
  endtask

  // Zero RTO makes every tick a timeout, so the retry count reaches its ceiling.
  task automatic test_retry_ceiling();
    write_reg(CfgInitialRto, 0);
    write_reg(CfgMaxPayload, 300);
    send_item(ActFill, 0, 0, 0, 900, 0);
    send_ack(1, 2000);
    repeat (260) send_item(ActTick, 0, 0, 0, 0, 0);
    send_ack(flight_abs(), 2000);
    write_reg(CfgInitialRto, 16'hFFFF);
  endtask

  // Random traffic in several register settings.
  task automatic test_random();
    bit [15:0] ready, win, ms;
    bit ended;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CfgInitialRto, (phase == 0) ? 16'hFFFF : $urandom_range(1, 3000));
      write_reg(CfgIsn, (phase == 1) ? 32'hFFFF_FFF0 : $urandom);
      write_reg(CfgMaxPayload, (phase == 2) ? 1452 : $urandom_range(1, 600));
      repeat (25) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            ready = ($urandom_range(0, 9) == 0) ? 16'hFFFF : $urandom_range(0, 5000);
            // A full buffer can never be drained in one window, so no FIN here.
            ended = (ready == 16'hFFFF) ? 1'b1 : 1'b0;
            send_item(ActFill, $urandom, $urandom, $urandom, ready, ended);
          end
          3, 4, 5: begin
            win = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 16'hFFFF
                                               : $urandom_range(1, 4000);
            if ($urandom_range(0, 7) == 0) send_item(ActAck, $urandom, win, 0, 0, 0);
            else send_ack($urandom_range(0, flight_abs()), win);
          end
          6, 7, 8: begin
            ms = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1500);
            send_item(ActTick, $urandom, $urandom, ms, $urandom, 0);
          end
          default: begin
            send_item(ActEmpty, $urandom, $urandom, $urandom, $urandom, 0);
          end
        endcase
      end
    end
  endtask

  // Close the stream: FIN, then traffic after it, with no idling.
  task automatic test_stream_end();
    calm = 1'b1;
    send_ack(flight_abs(), 16'hFFFF);
    send_item(ActFill, 0, 0, 0, 500, 1);
    send_item(ActFill, 0, 0, 0, 500, 1);
    send_item(ActTick, 0, 0, 16'hFFFF, 0, 0);
    send_ack(flight_abs(), 16'hFFFF);
    send_item(ActTick, 0, 0, 10, 0, 0);
    send_item(ActEmpty, 0, 0, 0, 0, 1);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Result checking, receiver stalls and the watchdog.
  always @(posedge clk_i) begin
    seg_desc_t d;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_segs.size() == 0) begin
          $display("%0t: unexpected beat %0h", $time, m_axis_tdata);
          failed = 1'b1;
        end else begin
          d = expected_segs.pop_front();
          check_field("seg_valid", d.vld, m_axis_tdata[0]);
          check_field("seg_seqno", d.seqno, m_axis_tdata[32:1]);
          check_field("seg_length", d.len, m_axis_tdata[43:33]);
          check_field("seg_syn", d.syn, m_axis_tdata[44]);
          check_field("seg_fin", d.fin, m_axis_tdata[45]);
          check_field("retransmit", d.retx, m_axis_tdata[46]);
          check_field("last", d.last, m_axis_tlast);
          check_field("in_flight", d.flight, m_axis_tdata[62:47]);
          check_field("retries", d.retries, m_axis_tdata[70:63]);
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgInitialRto;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    failed = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    rto_init = InitialRtoReset;
    isn_cfg = 0;
    payload_cfg = MaxPayloadReset;
    peer_window = 1;
    rto_now = InitialRtoReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_retry_ceiling();
    test_random();
    test_stream_end();

    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
